/* hw/rtl/shs_pkg.sv */
// shared types, constants and round functions for the sha-256 stream core
// no dependencies
package shs_pkg;

   typedef struct packed {
      logic       has_byte;
      logic [7:0] data_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [2:0]  word_index;
      logic [31:0] digest_word;
      logic        last_word;
   } rsp_type;

   // one message word between front and back
   typedef struct packed {
      logic [31:0] word;
      logic        msg_end;
   } qword_type;

   localparam int QDEPTH = 16;
   localparam int QPTR_W = $clog2(QDEPTH);

   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam logic [3:0] LEN_HI_IDX = 4'd14;
   localparam logic [6:0] ROUNDS     = 7'd64;

   localparam logic [31:0] IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] sig0(input logic [31:0] x);
      sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] sig1(input logic [31:0] x);
      sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] bsig0(input logic [31:0] x);
      bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] bsig1(input logic [31:0] x);
      bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

endpackage

/* hw/rtl/shs_front.sv */
// front: packs bytes into words, counts length, generates padding words
// depends on shs_pkg
module shs_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  shs_pkg::req_type   req_data,
   input  logic               q_full,
   output logic               q_push,
   output shs_pkg::qword_type q_data
);
   import shs_pkg::*;

   localparam logic [1:0] ST_BYTES  = 2'd0;
   localparam logic [1:0] ST_FIRST  = 2'd1;
   localparam logic [1:0] ST_FILL   = 2'd2;
   localparam logic [1:0] ST_LEN_LO = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [31:0] word_ff, word_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bitlen_ff, bitlen_in;
   logic [3:0]  wi_ff, wi_in;
   logic        accept;

   assign req_full = q_full || (state_ff != ST_BYTES);
   assign accept   = req_push && !req_full;

   always_comb begin
      state_in  = state_ff;
      word_in   = word_ff;
      fill_in   = fill_ff;
      bitlen_in = bitlen_ff;
      wi_in     = wi_ff;
      q_push    = 1'b0;
      q_data    = '{word: '0, msg_end: 1'b0};
      case (state_ff)
         ST_BYTES: begin
            if (accept && req_data.has_byte) begin
               word_in   = {word_ff[23:0], req_data.data_byte};
               fill_in   = fill_ff + 6'd1;
               bitlen_in = bitlen_ff + 64'd8;
               if (fill_ff[1:0] == 2'd3) begin
                  q_push = 1'b1;
                  q_data = '{word: word_in, msg_end: 1'b0};
               end
            end
            if (accept && req_data.end_of_message) begin
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            if (!q_full) begin
               q_push = 1'b1;
               case (fill_ff[1:0])
                  2'd0:    q_data.word = {PAD_BYTE, 24'h0};
                  2'd1:    q_data.word = {word_ff[7:0], PAD_BYTE, 16'h0};
                  2'd2:    q_data.word = {word_ff[15:0], PAD_BYTE, 8'h0};
                  default: q_data.word = {word_ff[23:0], PAD_BYTE};
               endcase
               wi_in    = fill_ff[5:2] + 4'd1;
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (!q_full) begin
               q_push = 1'b1;
               wi_in  = wi_ff + 4'd1;
               if (wi_ff == LEN_HI_IDX) begin
                  q_data.word = bitlen_ff[63:32];
                  state_in    = ST_LEN_LO;
               end
            end
         end
         default: begin
            if (!q_full) begin
               q_push    = 1'b1;
               q_data    = '{word: bitlen_ff[31:0], msg_end: 1'b1};
               fill_in   = '0;
               bitlen_in = '0;
               state_in  = ST_BYTES;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_BYTES;
         fill_ff   <= '0;
         bitlen_ff <= '0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         bitlen_ff <= bitlen_in;
      end
      word_ff <= word_in;
      wi_ff   <= wi_in;
   end

endmodule

/* hw/rtl/shs_fifo.sv */
// short word queue between front and back
// depends on shs_pkg
module shs_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  shs_pkg::qword_type push_data,
   output logic               full,
   input  logic               pop,
   output shs_pkg::qword_type pop_data,
   output logic               empty
);
   import shs_pkg::*;

   qword_type           mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ff, rd_ff;
   logic [QPTR_W:0]     cnt_ff;
   logic                do_push, do_pop;

   assign full     = (cnt_ff == (QPTR_W+1)'(QDEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
      end
      if (do_push) mem_ff[wr_ff] <= push_data;
   end

endmodule

/* hw/rtl/shs_back.sv */
// back: 64-round compression, chaining and digest output
// depends on shs_pkg
module shs_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  shs_pkg::qword_type q_data,
   output logic               q_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output shs_pkg::rsp_type   rsp_data
);
   import shs_pkg::*;

   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [31:0] chain_ff [8];
   logic [31:0] hold_ff [8];
   logic [31:0] w_ff [16];
   logic [6:0]  round_ff;
   logic        end_ff;
   logic        out_busy_ff;
   logic [2:0]  out_idx_ff;
   logic        step;
   logic        finish;
   logic [31:0] wi, t1, t2;

   assign wi = round_ff[6:4] == 3'd0 ? q_data.word
             : sig1(w_ff[14]) + w_ff[9] + sig0(w_ff[1]) + w_ff[0];
   assign q_pop  = (round_ff < 7'd16) && !q_empty;
   assign step   = (round_ff < ROUNDS) && ((round_ff >= 7'd16) || !q_empty);
   assign finish = (round_ff == ROUNDS) && !(end_ff && out_busy_ff);

   assign t1 = v_ff[7] + bsig1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
             + ROUND_K[round_ff[5:0]] + wi;
   assign t2 = bsig0(v_ff[0])
             + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));

   always_comb begin
      for (int i = 0; i < 8; i++) v_in[i] = chain_ff[i] + v_ff[i];
   end

   assign rsp_empty = !out_busy_ff;
   assign rsp_data  = '{word_index: out_idx_ff, digest_word: hold_ff[out_idx_ff],
                        last_word: (out_idx_ff == 3'd7)};

   always_ff @(posedge clock) begin
      if (reset) begin
         round_ff    <= '0;
         out_busy_ff <= 1'b0;
         out_idx_ff  <= '0;
         end_ff      <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            v_ff[i]     <= IV[i];
            chain_ff[i] <= IV[i];
         end
      end else begin
         if (step) begin
            v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
            v_ff[4] <= v_ff[3] + t1;
            v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
            v_ff[0] <= t1 + t2;
            round_ff <= round_ff + 7'd1;
            if (round_ff == 7'd15) end_ff <= q_data.msg_end;
         end
         if (finish) begin
            round_ff <= '0;
            if (end_ff) begin
               // digest out, chaining back to the initial values
               out_busy_ff <= 1'b1;
               out_idx_ff  <= '0;
               for (int i = 0; i < 8; i++) begin
                  v_ff[i]     <= IV[i];
                  chain_ff[i] <= IV[i];
               end
            end else begin
               for (int i = 0; i < 8; i++) begin
                  v_ff[i]     <= v_in[i];
                  chain_ff[i] <= v_in[i];
               end
            end
         end
         if (out_busy_ff && rsp_pop) begin
            out_idx_ff <= out_idx_ff + 3'd1;
            if (out_idx_ff == 3'd7) out_busy_ff <= 1'b0;
         end
      end
      if (step) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= wi;
      end
      if (finish && end_ff) begin
         for (int i = 0; i < 8; i++) hold_ff[i] <= v_in[i];
      end
   end

endmodule

/* hw/rtl/sha256_hash_stream_core.sv */
// top level of the sha-256 byte stream core
// depends on shs_pkg, shs_front, shs_fifo, shs_back
//
// channel   ports                           direction  item
// request   req_push req_full req_data      in         one byte and/or end mark
// response  rsp_pop rsp_empty rsp_data      out        one digest word, 8 per message
//
// one byte item per cycle while the word queue has room; the front packs
// four bytes to a word and the back runs one round per cycle while words are queued
// an end item holds off input while padding words are made,
// and also whenever the word queue is full
// the back waits at the last block of a message while the previous digest is read out
// synchronous reset brings chaining values to the initial hash, counts to zero
module sha256_hash_stream_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  shs_pkg::req_type req_data,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output shs_pkg::rsp_type rsp_data
);
   import shs_pkg::*;

   // word queue wiring
   logic      q_push, q_full, q_pop, q_empty;
   qword_type q_in, q_out;

   // front: byte packing and padding
   shs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_in)
   );

   // decouples byte intake from compression
   shs_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   // back: rounds, chaining, digest words
   shs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_out),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

/* bench/tb_sha256_hash_stream_core.sv */
// self-checking bench for the sha-256 byte stream core: directed and random messages
// depends on shs_pkg and sha256_hash_stream_core; digests predicted inside the bench
`timescale 1ns / 100ps

module tb_sha256_hash_stream_core;
   import shs_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 400;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_pop = 1'b0;
   logic    rsp_empty;
   rsp_type rsp_data;

   sha256_hash_stream_core u_top (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_pop(rsp_pop), .rsp_empty(rsp_empty), .rsp_data(rsp_data)
   );

   always #6 clock = ~clock;

   // hash state of the predictor
   logic [31:0] hash_state [8];
   logic [7:0]  msg_block [64];
   int unsigned block_fill;
   logic [63:0] msg_bits;

   req_type pending_items [$];
   rsp_type digest_words_due [$];

   int  mismatch_count = 0;
   int  stall_count = 0;
   bit  hold_receiver = 1'b0;  // receiver backpressure request
   bit  hold_sender = 1'b0;    // sender pause request

   // round helpers for the predictor
   function automatic logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void init_hash();
      hash_state = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                     32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      block_fill = 0;
      msg_bits = '0;
   endfunction

   function automatic void compress();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
              + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
      v = hash_state;
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++)
         hash_state[i] += v[i];
   endfunction

   function automatic void absorb_byte(logic [7:0] b);
      msg_block[block_fill] = b;
      block_fill = (block_fill + 1) % 64;
      if (block_fill == 0)
         compress();
   endfunction

   // advance the predictor by one accepted item, queueing any digest words
   function automatic void predict_digest(req_type it);
      logic [63:0] bits_snap;
      rsp_type     r;
      if (it.has_byte) begin
         msg_bits += 64'd8;
         absorb_byte(it.data_byte);
      end
      if (it.end_of_message) begin
         bits_snap = msg_bits;
         absorb_byte(PAD_BYTE);
         while (block_fill != 56)
            absorb_byte(8'h00);
         for (int i = 0; i < 8; i++)
            absorb_byte(bits_snap[63 - 8*i -: 8]);
         for (int i = 0; i < 8; i++) begin
            r.word_index  = 3'(i);
            r.digest_word = hash_state[i];
            r.last_word   = (i == 7);
            digest_words_due.push_back(r);
         end
         init_hash();
      end
   endfunction

   function automatic req_type mk(bit hb, logic [7:0] b, bit eom);
      req_type it;
      it.has_byte = hb; it.data_byte = b; it.end_of_message = eom;
      return it;
   endfunction

   // a whole message of n bytes with random content, ended by a byte or a bare marker
   function automatic void queue_message(int n, bit bare_end);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 15) == 0)
            pending_items.push_back(mk(1'b0, 8'($urandom), 1'b0));  // idle noise
         pending_items.push_back(mk(1'b1, 8'($urandom),
                                    !bare_end && i == n - 1));
      end
      if (bare_end || n == 0)
         pending_items.push_back(mk(1'b0, 8'($urandom), 1'b1));
   endfunction

   // handshake state sampled at the rising edge
   logic req_full_at_pos;
   logic rsp_empty_at_pos;

   // sender: draws a gap per item, drives at the falling edge
   int send_gap = 0;
   req_type cur_item;
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (req_push && !req_full_at_pos) begin
         // previous item went in at the last rising edge
         if (send_gap == 0 && !hold_sender && pending_items.size() > 0) begin
            cur_item = pending_items.pop_front();
            req_data <= cur_item;
            req_push <= 1'b1;
            send_gap = $urandom_range(0, 9) > 5 ? $urandom_range(0, 9) : 0;
         end else begin
            req_push <= 1'b0;
         end
      end else if (!req_push) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (!hold_sender && pending_items.size() > 0) begin
            cur_item = pending_items.pop_front();
            req_data <= cur_item;
            req_push <= 1'b1;
            send_gap = $urandom_range(0, 9) > 5 ? $urandom_range(0, 9) : 0;
         end
      end
   end

   // acceptance is sampled at the rising edge
   int   recv_gap = 0;
   int   hold_left = 0;
   bit   hold_seen = 1'b0;

   always @(posedge clock) begin
      req_full_at_pos  <= req_full;
      rsp_empty_at_pos <= rsp_empty;
      if (!reset) begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
            stall_count = 0;
         else
            stall_count = stall_count + 1;
         if (req_push && !req_full)
            predict_digest(req_data);
         if (rsp_pop && !rsp_empty) begin
            if (digest_words_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected digest word: %p", rsp_data);
            end else if (rsp_data !== digest_words_due[0]) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("digest mismatch: expected %p actual %p",
                           digest_words_due[0], rsp_data);
               void'(digest_words_due.pop_front());
            end else begin
               void'(digest_words_due.pop_front());
            end
         end
         if (stall_count >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // receiver: draws a stall per word, plus one long hold-off counted here
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else if (hold_receiver && !hold_seen) begin
         hold_seen = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_pop <= 1'b0;
      end else if (rsp_pop && !rsp_empty_at_pos) begin
         recv_gap = $urandom_range(0, 9) > 5 ? $urandom_range(0, 9) : 0;
         rsp_pop <= (recv_gap == 0);
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_pop <= (recv_gap == 0);
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   initial begin
      int len;
      init_hash();
      for (int i = 0; i < 64; i++) msg_block[i] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: empty message, ignored byte on idle items, one-byte extremes
      pending_items.push_back(mk(1'b0, 8'hff, 1'b1));
      pending_items.push_back(mk(1'b0, 8'haa, 1'b0));
      pending_items.push_back(mk(1'b1, 8'h00, 1'b1));
      pending_items.push_back(mk(1'b1, 8'hff, 1'b1));
      pending_items.push_back(mk(1'b0, 8'h55, 1'b0));
      pending_items.push_back(mk(1'b0, 8'h00, 1'b1));
      // "abc" ended by a bare marker
      pending_items.push_back(mk(1'b1, 8'h61, 1'b0));
      pending_items.push_back(mk(1'b1, 8'h62, 1'b0));
      pending_items.push_back(mk(1'b1, 8'h63, 1'b0));
      pending_items.push_back(mk(1'b0, 8'h00, 1'b1));
      wait (pending_items.size() == 0);

      // long receiver hold-off while messages keep flowing, input must stall
      hold_receiver = 1'b1;
      for (int m = 0; m < 4; m++)
         queue_message($urandom_range(0, 8), $urandom_range(0, 1));
      wait (pending_items.size() == 0 && hold_seen && hold_left == 0);

      // sender pause until every digest word is back
      hold_sender = 1'b1;
      wait (!req_push && digest_words_due.size() == 0);
      hold_sender = 1'b0;

      // padding boundaries: lengths around 55, 56 and 64 bytes
      queue_message(55, 1'b0);
      queue_message(56, 1'b1);
      queue_message(64, 1'b0);
      wait (pending_items.size() == 0);

      // random short messages, with idle noise inside
      len = 0;
      while (len < 24) begin
         int n;
         n = $urandom_range(0, 20);
         queue_message(n, $urandom_range(0, 3) == 0);
         len += n + 1;
         wait (pending_items.size() < 4);
      end
      wait (pending_items.size() == 0 && !req_push);
      wait (digest_words_due.size() == 0);
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && digest_words_due.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/shs_pkg.sv
hw/rtl/shs_front.sv
hw/rtl/shs_fifo.sv
hw/rtl/shs_back.sv
hw/rtl/sha256_hash_stream_core.sv
bench/tb_sha256_hash_stream_core.sv
